/* sv/brb_pkg.sv */
package brb_pkg;

   // Field widths of the request and response transactions.
   localparam int ACTION_W = 2;
   localparam int OFFSET_W = 36;
   localparam int SIZE_W   = 37;
   localparam int START_W  = 12;
   localparam int NEXT_W   = 12;
   localparam int BSL_W    = 5;

   // offset + length needs one bit more than a size.
   localparam int SUM_W = SIZE_W + 1;

   // Block size limits, in log2 of bytes.
   localparam logic [BSL_W-1:0] BSL_MIN   = 5'd9;
   localparam logic [BSL_W-1:0] BSL_MAX   = 5'd24;
   localparam logic [BSL_W-1:0] BSL_RESET = 5'd12;

   // A block count after the smallest block shift, plus one for rounding up.
   localparam int BLK_CNT_W = SUM_W - 9 + 1;
   // First block of a range, taken from the offset alone.
   localparam int FIRST_W   = OFFSET_W - 9;

   // The search extent is a whole number of this many blocks.
   localparam int ROUND_BLOCKS = 8;
   localparam int ROUND_LOG    = $clog2(ROUND_BLOCKS);

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_MARK   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESIZE = 2'd2;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_IDX_BSL = 2'd0;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   length;
      logic [START_W-1:0]  start_block;
      logic [SIZE_W-1:0]   new_size;
   } req_item_type;

   typedef struct packed {
      logic              found;
      logic [NEXT_W-1:0] next_block;
      logic              overflow;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_COUNT,
      ST_LIMIT,
      ST_PLAN,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      WOP_MARK,
      WOP_FIND,
      WOP_CLEAR
   } walk_op_type;

   typedef struct packed {
      logic        go;
      walk_op_type op;
   } walk_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } walk_sts_type;

endpackage

/* sv/brb_ram.sv */
module brb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/brb_csr.sv */
module brb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [brb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [brb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [brb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [brb_pkg::BSL_W-1:0]        bsl
);
   import brb_pkg::*;

   logic [BSL_W-1:0]      bsl_ff;
   logic [BSL_W-1:0]      bsl_in;
   logic [BSL_W-1:0]      wr_value;
   logic [CSR_ADDR_W-1:0] reg_idx;
   logic                  wr_hit;

   assign pready  = 1'b1;
   assign reg_idx = paddr >> 2;
   assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_IDX_BSL);

   // Written values are clamped to the supported block sizes.
   always_comb begin
      wr_value = pwdata[BSL_W-1:0];
      if (wr_value < BSL_MIN) begin
         wr_value = BSL_MIN;
      end else if (wr_value > BSL_MAX) begin
         wr_value = BSL_MAX;
      end
      bsl_in = wr_hit ? wr_value : bsl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsl_ff <= BSL_RESET;
      end else begin
         bsl_ff <= bsl_in;
      end
   end

   assign prdata = (reg_idx == REG_IDX_BSL) ? CSR_DATA_W'(bsl_ff) : '0;
   assign bsl    = bsl_ff;

endmodule

/* sv/brb_walk.sv */
module brb_walk #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 64,
   localparam int BI_W = $clog2(MAX_BLOCKS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  brb_pkg::walk_cmd_type cmd,
   input  logic [BI_W-1:0]       first_blk,
   input  logic [BI_W-1:0]       last_blk,
   output brb_pkg::walk_sts_type sts,
   output logic [BI_W-1:0]       hit_blk
);
   import brb_pkg::*;

   localparam int NUM_WORDS = MAX_BLOCKS / WORD_BITS;
   localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);

   walk_op_type          op_ff, op_in;
   logic [BI_W-1:0]      first_ff, first_in;
   logic [BI_W-1:0]      last_ff, last_in;
   logic [WA_W-1:0]      iss_ptr_ff, iss_ptr_in;
   logic                 iss_live_ff, iss_live_in;
   logic                 dat_live_ff, dat_live_in;
   logic [WA_W-1:0]      dat_addr_ff, dat_addr_in;
   logic [NUM_WORDS-1:0] valid_ff, valid_in;
   walk_sts_type         sts_ff, sts_in;
   logic [BI_W-1:0]      hit_blk_ff, hit_blk_in;

   logic [WA_W-1:0]      first_word;
   logic [WA_W-1:0]      last_word;
   logic [BIT_W-1:0]     lo_bit;
   logic [BIT_W-1:0]     hi_bit;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] ram_rdata;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] wr_word;
   logic [WORD_BITS-1:0] hit_bits;
   logic [BIT_W-1:0]     hit_pos;
   logic                 hit;
   logic                 wr_en;
   logic                 last;
   logic                 finish;

   brb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (dat_addr_ff),
      .wdata (wr_word),
      .re    (iss_live_ff),
      .raddr (iss_ptr_ff),
      .rdata (ram_rdata)
   );

   assign first_word = WA_W'(first_ff >> BIT_W);
   assign last_word  = WA_W'(last_ff >> BIT_W);

   // Only the end words of the range are partial.
   assign lo_bit = (dat_addr_ff == first_word) ? first_ff[BIT_W-1:0] : '0;
   assign hi_bit = (dat_addr_ff == last_word) ? last_ff[BIT_W-1:0] : '1;
   assign mask   = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (~hi_bit));

   // A word never written since reset reads as zero.
   assign rd_word  = valid_ff[dat_addr_ff] ? ram_rdata : '0;
   assign hit_bits = rd_word & mask;
   assign hit      = |hit_bits;

   always_comb begin
      hit_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (hit_bits[i]) begin
            hit_pos = BIT_W'(i);
         end
      end
   end

   always_comb begin
      case (op_ff)
         WOP_CLEAR: wr_word = rd_word & ~mask;
         default:   wr_word = rd_word | mask;
      endcase
   end

   assign wr_en  = dat_live_ff && (op_ff != WOP_FIND);
   assign last   = dat_addr_ff == last_word;
   assign finish = dat_live_ff && (last || ((op_ff == WOP_FIND) && hit));

   always_comb begin
      op_in       = op_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      iss_ptr_in  = iss_ptr_ff;
      iss_live_in = iss_live_ff;
      dat_live_in = 1'b0;
      dat_addr_in = iss_ptr_ff;
      if (cmd.go) begin
         op_in       = cmd.op;
         first_in    = first_blk;
         last_in     = last_blk;
         iss_ptr_in  = WA_W'(first_blk >> BIT_W);
         iss_live_in = 1'b1;
      end else begin
         if (iss_live_ff) begin
            iss_ptr_in = WA_W'(iss_ptr_ff + 1'b1);
         end
         iss_live_in = iss_live_ff && (iss_ptr_ff != last_word) && !finish;
         dat_live_in = iss_live_ff && !finish;
      end

      sts_in.done  = finish;
      sts_in.found = finish && (op_ff == WOP_FIND) && hit;
      hit_blk_in   = finish ? BI_W'({dat_addr_ff, hit_pos}) : hit_blk_ff;

      for (int i = 0; i < NUM_WORDS; i++) begin
         valid_in[i] = valid_ff[i] || (wr_en && (dat_addr_ff == WA_W'(i)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_live_ff <= 1'b0;
         dat_live_ff <= 1'b0;
         valid_ff    <= '0;
         sts_ff      <= '0;
      end else begin
         iss_live_ff <= iss_live_in;
         dat_live_ff <= dat_live_in;
         valid_ff    <= valid_in;
         sts_ff      <= sts_in;
      end
      op_ff       <= op_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      iss_ptr_ff  <= iss_ptr_in;
      dat_addr_ff <= dat_addr_in;
      hit_blk_ff  <= hit_blk_in;
   end

   assign sts     = sts_ff;
   assign hit_blk = hit_blk_ff;

endmodule

/* sv/block_range_bitmap.sv */
// An accepted transaction steps through the SUM, COUNT, LIMIT and PLAN states. One that touches
// no bitmap word is then strobed out from RESP; one that walks bitmap words (one word per cycle
// through the RAM) passes through WALK before RESP. A new transaction may be accepted in the
// cycle its response is strobed.
// Reset clears the object size, the block size register (to 4 KiB) and the per-word valid
// flags at once, so the bitmap reads as all zero with no clearing pass. No stall on responses.
module block_range_bitmap #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 64,
   localparam int BI_W = $clog2(MAX_BLOCKS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  brb_pkg::req_item_type          req_item,
   output logic                           rsp_strobe,
   output brb_pkg::rsp_item_type          rsp_item,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [brb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [brb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [brb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import brb_pkg::*;

   // Bitmap capacity as a block count, for comparisons.
   localparam logic [BLK_CNT_W-1:0] MAX_CNT = BLK_CNT_W'(MAX_BLOCKS);

   state_type            state_ff, state_in;
   req_item_type         req_ff, req_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [BLK_CNT_W-1:0] blk_ff, blk_in;
   logic [FIRST_W-1:0]   first_ff, first_in;
   logic                 big_ff, big_in;
   logic                 grow_ff, grow_in;
   logic                 shrink_ff, shrink_in;
   logic                 ovf_ff, ovf_in;
   logic [BLK_CNT_W-1:0] ext_ff, ext_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic                 res_found_ff, res_found_in;
   logic [NEXT_W-1:0]    res_next_ff, res_next_in;
   logic                 res_ovf_ff, res_ovf_in;

   logic [BSL_W-1:0]     bsl;
   logic                 accept;
   logic [SUM_W-1:0]     quant;
   logic [SUM_W-1:0]     quant_shift;
   logic                 quant_rem;
   logic [BLK_CNT_W-1:0] round_units;
   logic [BLK_CNT_W-1:0] rounded;
   logic                 plan_go;
   walk_op_type          plan_op;
   logic [BI_W-1:0]      plan_first;
   logic [BI_W-1:0]      plan_last;
   walk_cmd_type         walk_cmd;
   walk_sts_type         walk_sts;
   logic [BI_W-1:0]      walk_hit_blk;

   // The block size register, on the APB-style port.
   brb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .bsl     (bsl)
   );

   // The word walker owns the bitmap RAM. It reads one word per cycle and, for marking and
   // clearing, writes the modified word back the cycle its read data returns.
   brb_walk #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .cmd       (walk_cmd),
      .first_blk (plan_first),
      .last_blk  (plan_last),
      .sts       (walk_sts),
      .hit_blk   (walk_hit_blk)
   );

   assign accept = start && !busy;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SUM;
         ST_SUM:   state_in = ST_COUNT;
         ST_COUNT: state_in = ST_LIMIT;
         ST_LIMIT: state_in = ST_PLAN;
         ST_PLAN:  state_in = plan_go ? ST_WALK : ST_RESP;
         ST_WALK:  if (walk_sts.done) state_in = ST_RESP;
         ST_RESP:  state_in = accept ? ST_SUM : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs. The response cycle already accepts the next transaction.
   always_comb begin
      busy        = 1'b1;
      rsp_strobe  = 1'b0;
      walk_cmd.go = 1'b0;
      walk_cmd.op = plan_op;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_PLAN: walk_cmd.go = plan_go;
         ST_RESP: begin
            busy       = 1'b0;
            rsp_strobe = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   // Block count of the quantity this action needs: the range end for a mark, the current
   // size for a search and the new size for a resize. The count is rounded up.
   always_comb begin
      case (req_ff.action)
         ACT_MARK: quant = sum_ff;
         ACT_FIND: quant = SUM_W'(size_ff);
         default:  quant = SUM_W'(req_ff.new_size);
      endcase
      quant_shift = quant >> bsl;
      quant_rem   = |(quant & ~({SUM_W{1'b1}} << bsl));
   end

   // Extent: the block count rounded up to a multiple of eight, capped at capacity.
   always_comb begin
      round_units = (blk_ff >> ROUND_LOG) + BLK_CNT_W'(|blk_ff[ROUND_LOG-1:0]);
      rounded     = round_units << ROUND_LOG;
   end

   // Walk plan, decided once the counts are known. A mark covers its first through last
   // touched block; a search runs from the start block to the end of the extent; a shrink
   // clears everything from the new extent to the top of the bitmap.
   always_comb begin
      plan_go    = 1'b0;
      plan_op    = WOP_FIND;
      plan_first = BI_W'(req_ff.start_block);
      plan_last  = BI_W'(ext_ff - 1'b1);
      case (req_ff.action)
         ACT_MARK: begin
            plan_op    = WOP_MARK;
            plan_first = BI_W'(first_ff);
            plan_last  = BI_W'(blk_ff - 1'b1);
            plan_go    = !ovf_ff && (blk_ff > BLK_CNT_W'(first_ff));
         end
         ACT_FIND: begin
            plan_go = BLK_CNT_W'(req_ff.start_block) < ext_ff;
         end
         ACT_RESIZE: begin
            plan_op    = WOP_CLEAR;
            plan_first = BI_W'(ext_ff);
            plan_last  = '1;
            plan_go    = !ovf_ff && shrink_ff && (ext_ff < MAX_CNT);
         end
         default: plan_go = 1'b0;
      endcase
   end

   // Datapath registers, each loaded in the state that produces it.
   always_comb begin
      req_in       = accept ? req_item : req_ff;
      sum_in       = sum_ff;
      blk_in       = blk_ff;
      first_in     = first_ff;
      big_in       = big_ff;
      grow_in      = grow_ff;
      shrink_in    = shrink_ff;
      ovf_in       = ovf_ff;
      ext_in       = ext_ff;
      size_in      = size_ff;
      res_found_in = res_found_ff;
      res_next_in  = res_next_ff;
      res_ovf_in   = res_ovf_ff;
      case (state_ff)
         ST_SUM: begin
            sum_in = SUM_W'(req_ff.offset) + SUM_W'(req_ff.length);
         end
         ST_COUNT: begin
            blk_in    = BLK_CNT_W'(quant_shift) + BLK_CNT_W'(quant_rem);
            first_in  = FIRST_W'(req_ff.offset >> bsl);
            big_in    = sum_ff[SUM_W-1];
            grow_in   = sum_ff > SUM_W'(size_ff);
            shrink_in = req_ff.new_size < size_ff;
         end
         ST_LIMIT: begin
            ovf_in = ((req_ff.action == ACT_MARK) && (big_ff || (blk_ff > MAX_CNT)))
                  || ((req_ff.action == ACT_RESIZE) && (blk_ff > MAX_CNT));
            ext_in = (rounded > MAX_CNT) ? MAX_CNT : rounded;
         end
         ST_PLAN: begin
            res_found_in = 1'b0;
            res_next_in  = '0;
            res_ovf_in   = ovf_ff;
            if ((req_ff.action == ACT_MARK) && !ovf_ff && grow_ff) begin
               size_in = sum_ff[SIZE_W-1:0];
            end
            if ((req_ff.action == ACT_RESIZE) && !ovf_ff) begin
               size_in = req_ff.new_size;
            end
         end
         ST_WALK: begin
            if (walk_sts.done) begin
               res_found_in = walk_sts.found;
               res_next_in  = walk_sts.found ? NEXT_W'(walk_hit_blk) : '0;
            end
         end
         default: begin
            size_in = size_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
      req_ff       <= req_in;
      sum_ff       <= sum_in;
      blk_ff       <= blk_in;
      first_ff     <= first_in;
      big_ff       <= big_in;
      grow_ff      <= grow_in;
      shrink_ff    <= shrink_in;
      ovf_ff       <= ovf_in;
      ext_ff       <= ext_in;
      res_found_ff <= res_found_in;
      res_next_ff  <= res_next_in;
      res_ovf_ff   <= res_ovf_in;
   end

   assign rsp_item.found      = res_found_ff;
   assign rsp_item.next_block = res_next_ff;
   assign rsp_item.overflow   = res_ovf_ff;

endmodule
